// ===== rtl/rcfd_pkg.sv =====
// Shared types, constants and field helpers for the remote-control frame decoder.
package rcfd_pkg;

  // Frame geometry
  localparam int FRAME_LEN = 18;
  localparam int CNT_W     = $clog2(FRAME_LEN + 1);
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FRAME_LEN);

  // Smoothing window default
  localparam int SMOOTH_DEPTH_DEF = 8;

  // Output sum range (19-bit signed)
  localparam int SUM_W = 19;
  localparam logic signed [31:0] SUM_MAX = 32'sd262143;
  localparam logic signed [31:0] SUM_MIN = -32'sd262144;

  // Frame-to-back queue depth
  localparam int QDEPTH = 2;

  // One complete frame, byte 0 in the lowest slot
  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

  // Raw 11-bit channel minus 1024, as 11-bit two's complement
  function automatic logic [10:0] chan_offset(input logic [10:0] raw);
    chan_offset = {~raw[10], raw[9:0]};
  endfunction

endpackage

// ===== rtl/rcfd_front.sv =====
// Front end: collects received bytes into a frame and hands complete frames on.
module rcfd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic [7:0]      rx_byte,
  input  logic            frame_start,
  input  logic            accept,
  output logic            frame_push,
  output rcfd_pkg::frame_t frame_data
);
  import rcfd_pkg::*;

  logic [CNT_W-1:0] byte_count;
  logic [7:0]       store [FRAME_LEN-1];
  logic             open_slot;

  // A plain byte lands only inside an open, unfinished frame
  assign open_slot  = (byte_count != '0) && (byte_count < FULL_CNT);
  assign frame_push = accept && !frame_start && (byte_count == LAST_POS);

  // Complete frame: stored bytes plus the closing byte
  always_comb begin
    for (int i = 0; i < FRAME_LEN - 1; i++) begin
      frame_data[i] = store[i];
    end
    frame_data[FRAME_LEN-1] = rx_byte;
  end

  // Byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (accept) begin
      if (frame_start) begin
        byte_count <= CNT_W'(1);
      end else if (open_slot) begin
        byte_count <= byte_count + CNT_W'(1);
      end
    end
  end

  // Frame byte store; the closing byte goes straight to the queue
  always_ff @(posedge clk) begin
    if (accept) begin
      if (frame_start) begin
        store[0] <= rx_byte;
      end else if (open_slot && (byte_count != LAST_POS)) begin
        store[byte_count] <= rx_byte;
      end
    end
  end

endmodule

// ===== rtl/rcfd_queue.sv =====
// Short frame queue between the front end and the back end.
module rcfd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  rcfd_pkg::frame_t push_data,
  output logic             full,
  input  logic             pop,
  output rcfd_pkg::frame_t pop_data,
  output logic             empty
);
  import rcfd_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  frame_t           mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full     = (count == (PTR_W + 1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + (PTR_W + 1)'(1);
        2'b01:   count <= count - (PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== rtl/rcfd_back.sv =====
// Back end: decodes a frame, updates the mouse smoothing window, holds the result.
module rcfd_back #(
  parameter int SMOOTH_DEPTH = rcfd_pkg::SMOOTH_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  rcfd_pkg::frame_t    frame_data,
  input  logic                frame_avail,
  output logic                frame_take,
  input  logic                pop,
  output logic                empty,
  output logic signed [10:0]  stick_ch0,
  output logic signed [10:0]  stick_ch1,
  output logic signed [10:0]  stick_ch2,
  output logic signed [10:0]  stick_ch3,
  output logic signed [10:0]  wheel_value,
  output logic [3:0]          switch_bits,
  output logic signed [15:0]  mouse_speed_x,
  output logic signed [15:0]  mouse_speed_y,
  output logic signed [15:0]  mouse_speed_z,
  output logic signed [18:0]  smooth_x_sum,
  output logic signed [18:0]  smooth_y_sum,
  output logic [17:0]         key_buttons
);
  import rcfd_pkg::*;

  // Exact window totals: 16-bit speeds times the depth
  localparam int TOT_W = 17 + $clog2(SMOOTH_DEPTH);

  logic signed [15:0]      x_hist [SMOOTH_DEPTH];
  logic signed [15:0]      y_hist [SMOOTH_DEPTH];
  logic signed [TOT_W-1:0] x_total;
  logic signed [TOT_W-1:0] y_total;
  logic signed [TOT_W-1:0] x_total_next;
  logic signed [TOT_W-1:0] y_total_next;
  logic signed [31:0]      x_wide;
  logic signed [31:0]      y_wide;
  logic signed [15:0]      sx;
  logic signed [15:0]      sy;
  logic                    out_valid;

  assign empty      = !out_valid;
  assign frame_take = frame_avail && (!out_valid || pop);

  assign sx = {frame_data[7], frame_data[6]};
  assign sy = {frame_data[9], frame_data[8]};

  // Window totals: drop the oldest speed, add the new one
  always_comb begin
    x_total_next = x_total - TOT_W'(x_hist[SMOOTH_DEPTH-1]) + TOT_W'(sx);
    y_total_next = y_total - TOT_W'(y_hist[SMOOTH_DEPTH-1]) + TOT_W'(sy);
    x_wide       = 32'(x_total_next);
    y_wide       = 32'(y_total_next);
  end

  // History windows and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      x_total <= '0;
      y_total <= '0;
      for (int i = 0; i < SMOOTH_DEPTH; i++) begin
        x_hist[i] <= '0;
        y_hist[i] <= '0;
      end
    end else if (frame_take) begin
      x_total   <= x_total_next;
      y_total   <= y_total_next;
      x_hist[0] <= sx;
      y_hist[0] <= sy;
      for (int i = 1; i < SMOOTH_DEPTH; i++) begin
        x_hist[i] <= x_hist[i-1];
        y_hist[i] <= y_hist[i-1];
      end
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frame_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result fields
  always_ff @(posedge clk) begin
    if (frame_take) begin
      stick_ch0   <= chan_offset({frame_data[1][2:0], frame_data[0]});
      stick_ch1   <= chan_offset({frame_data[2][5:0], frame_data[1][7:3]});
      stick_ch2   <= chan_offset({frame_data[4][0], frame_data[3], frame_data[2][7:6]});
      stick_ch3   <= chan_offset({frame_data[5][3:0], frame_data[4][7:1]});
      wheel_value <= chan_offset({frame_data[17][2:0], frame_data[16]});
      switch_bits <= frame_data[5][7:4];
      mouse_speed_x <= sx;
      mouse_speed_y <= sy;
      mouse_speed_z <= {frame_data[11], frame_data[10]};
      key_buttons <= {frame_data[13][0], frame_data[12][0], frame_data[15], frame_data[14]};
      // Saturate the totals to the output range
      if (x_wide > SUM_MAX) begin
        smooth_x_sum <= SUM_W'(SUM_MAX);
      end else if (x_wide < SUM_MIN) begin
        smooth_x_sum <= SUM_W'(SUM_MIN);
      end else begin
        smooth_x_sum <= SUM_W'(x_wide);
      end
      if (y_wide > SUM_MAX) begin
        smooth_y_sum <= SUM_W'(SUM_MAX);
      end else if (y_wide < SUM_MIN) begin
        smooth_y_sum <= SUM_W'(SUM_MIN);
      end else begin
        smooth_y_sum <= SUM_W'(y_wide);
      end
    end
  end

endmodule

// ===== rtl/rc_frame_decoder_with_mouse_smoothing.sv =====
// Top level: remote-control frame decoder with mouse-speed smoothing.
// A frame is queued on its 18th byte, then decoded from the queue into the result registers;
//   a result still waiting to be popped holds later frames in the queue.
// Throughput: one byte per cycle unless full; full needs two frames behind an unpopped result.
// Reset (rst, synchronous): byte count, queue and result valid cleared;
//   smoothing windows and totals cleared to zero.
module rc_frame_decoder_with_mouse_smoothing #(
  parameter int SMOOTH_DEPTH = rcfd_pkg::SMOOTH_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte,
  input  logic               frame_start,
  input  logic               pop,
  output logic               empty,
  output logic signed [10:0] stick_ch0,
  output logic signed [10:0] stick_ch1,
  output logic signed [10:0] stick_ch2,
  output logic signed [10:0] stick_ch3,
  output logic signed [10:0] wheel_value,
  output logic [3:0]         switch_bits,
  output logic signed [15:0] mouse_speed_x,
  output logic signed [15:0] mouse_speed_y,
  output logic signed [15:0] mouse_speed_z,
  output logic signed [18:0] smooth_x_sum,
  output logic signed [18:0] smooth_y_sum,
  output logic [17:0]        key_buttons
);
  import rcfd_pkg::*;

  logic   accept;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  frame_t q_in;
  frame_t q_out;

  assign full   = q_full;
  assign accept = push && !q_full;

  // Byte collection
  rcfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .accept      (accept),
    .frame_push  (q_push),
    .frame_data  (q_in)
  );

  // Frame queue
  rcfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // Decode and smoothing
  rcfd_back #(
    .SMOOTH_DEPTH (SMOOTH_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .frame_data    (q_out),
    .frame_avail   (!q_empty),
    .frame_take    (q_pop),
    .pop           (pop),
    .empty         (empty),
    .stick_ch0     (stick_ch0),
    .stick_ch1     (stick_ch1),
    .stick_ch2     (stick_ch2),
    .stick_ch3     (stick_ch3),
    .wheel_value   (wheel_value),
    .switch_bits   (switch_bits),
    .mouse_speed_x (mouse_speed_x),
    .mouse_speed_y (mouse_speed_y),
    .mouse_speed_z (mouse_speed_z),
    .smooth_x_sum  (smooth_x_sum),
    .smooth_y_sum  (smooth_y_sum),
    .key_buttons   (key_buttons)
  );

  // A frame enters the queue only on an accepted closing beat
  a_push_on_close: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (accept && !frame_start))
    else $error("frame queued without a closing beat");

  // Never queue into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("frame queue overflow");

  // Never take from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("frame queue underflow");

  // A new result appears only after a frame was taken from the queue
  a_result_from_frame: assert property (@(posedge clk) disable iff (rst)
    $fell(empty) |-> $past(q_pop))
    else $error("result appeared without a frame");

endmodule
